### hdl/pidc_pkg.sv
package pidc_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned DT_W   = 21;
  localparam int unsigned MA_W   = 32;
  localparam int unsigned MB_W   = 33;
  localparam int unsigned MP_W   = MA_W + MB_W + 2;

  localparam logic [2:0] REG_GAIN_P     = 3'd0;
  localparam logic [2:0] REG_GAIN_I     = 3'd1;
  localparam logic [2:0] REG_GAIN_D     = 3'd2;
  localparam logic [2:0] REG_SETPOINT   = 3'd3;
  localparam logic [2:0] REG_OUT_MIN    = 3'd4;
  localparam logic [2:0] REG_OUT_MAX    = 3'd5;
  localparam logic [2:0] REG_START_ERR  = 3'd6;
  localparam logic [2:0] REG_START_MEAS = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DLOAD,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    OP_P,
    OP_KI,
    OP_INC,
    OP_A,
    OP_B
  } op_e;

  function automatic logic signed [31:0] sat66(input logic signed [65:0] x);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (x > hi) begin
      sat66 = 32'sh7fffffff;
    end else if (x < lo) begin
      sat66 = 32'sh80000000;
    end else begin
      sat66 = x[31:0];
    end
  endfunction

endpackage

### hdl/pidc_mul.sv
module pidc_mul
  import pidc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [MA_W-1:0]  a_i,
  input  logic signed [MB_W-1:0]  b_i,
  output logic                    done_o,
  output logic signed [MP_W-1:0]  prod_o
);

  localparam int unsigned CNT_W = $clog2(MB_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MB_W - 1);

  logic                    run_q, run_d;
  logic                    done_q, done_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [MA_W-1:0]  a_q, a_d;
  logic signed [MA_W+1:0]  hi_q, hi_d;
  logic [MB_W-1:0]         lo_q, lo_d;
  logic signed [MA_W+1:0]  addend;
  logic signed [MA_W+1:0]  sum;

  always_comb begin
    addend = '0;
    if (lo_q[0]) begin
      if (cnt_q == LAST) begin
        addend = -(MA_W+2)'(a_q);
      end else begin
        addend = (MA_W+2)'(a_q);
      end
    end
    sum = hi_q + addend;
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      a_d   = a_i;
      hi_d  = '0;
      lo_d  = b_i;
    end else if (run_q) begin
      hi_d = {sum[MA_W+1], sum[MA_W+1:1]};
      lo_d = {sum[0], lo_q[MB_W-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

### hdl/pidc_div.sv
module pidc_div
  import pidc_pkg::*;
#(
  parameter int unsigned NW = 49,
  parameter int unsigned DW = 22
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NW);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NW - 1);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NW-1:0]    n_q, n_d;
  logic [DW-1:0]    den_q, den_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, n_q[NW-1]};
    ge    = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    n_d    = n_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      n_d   = num_i;
      den_d = den_i;
      rem_d = '0;
    end else if (run_q) begin
      rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
      n_d   = {n_q[NW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = n_q;

endmodule

### hdl/pid_controller_step.sv
// PID controller step with anti-windup integrator and filtered derivative.
// Input channel: sample_i and step_time_i with in_valid_i; the block raises
// in_stall_o while it works on a transaction. Output channel: drive_o with
// out_valid_o, held until the receiver drops out_stall_i.
// Registers are written over the APB-style port (pready is tied high), one
// per word at byte address 4*index; writing start_prev_error or
// start_prev_measure also loads the matching history value.
// From acceptance to out_valid_o, a transaction passes five products through
// one bit-serial multiplier, each a load step and then the multiplier run,
// then a load step and a restoring divider, then a last step to sum and
// clamp. Items are handled one at a time; the next one is taken only once
// the block is back in idle.
// A finished result waits in the output register; the next transaction is
// taken meanwhile, and its result waits in the last step until the output
// register frees up.
// Reset clears the history and integrator, sets the limits to full range
// and leaves both channels empty.
module pid_controller_step
  import pidc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] sample_i,
  input  logic [DT_W-1:0]          step_time_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] drive_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam int unsigned TAU     = ((2 ** FRAC_BITS) + 25) / 50;
  localparam int unsigned TWO_TAU = 2 * TAU;
  localparam int unsigned DW      = $clog2(TWO_TAU + (2 ** DT_W));
  localparam int unsigned NW      = DATA_W + 1 + FRAC_BITS;
  localparam logic signed [65:0] RND_F  = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] RND_F1 = 66'sd1 <<< FRAC_BITS;
  localparam logic signed [65:0] RND_FM = 66'sd1 <<< (FRAC_BITS - 2);

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic signed [31:0] gain_p_q, gain_i_q, gain_d_q, setpoint_q;
  logic signed [31:0] out_min_q, out_max_q, start_err_q, start_meas_q;
  logic signed [31:0] prev_err_q, prev_meas_q, integ_q, deriv_q;

  logic signed [31:0] sample_q, err_q, dm_q;
  logic [DT_W-1:0]    dt_q;
  logic [DW-1:0]      den_q;
  logic signed [31:0] prop_q, kidt_q, inc_q, a_q, b_q;
  logic               neg_q;
  logic               out_valid_q;
  logic signed [31:0] drive_q;

  logic               in_fire, cfg_wr, mul_start, div_start, fin_fire;
  logic               mul_done, div_done;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] mul_prod;
  logic signed [65:0] prod_w, rounded;
  logic signed [31:0] rnd_sat;
  logic [NW-1:0]      div_num, div_quo;
  logic signed [32:0] num_w;
  logic signed [31:0] num_s;
  logic [31:0]        num_mag;
  logic signed [31:0] err_c, dm_c, e2;
  logic signed [33:0] integ_sum, hi_w, lo_w, drive_w;
  logic signed [31:0] integ_s, hi_i, lo_i, integ_c, deriv_c, drive_s, drive_c;

  assign in_fire = in_valid_i && !in_stall_o;
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      REG_GAIN_P:     prdata = gain_p_q;
      REG_GAIN_I:     prdata = gain_i_q;
      REG_GAIN_D:     prdata = gain_d_q;
      REG_SETPOINT:   prdata = setpoint_q;
      REG_OUT_MIN:    prdata = out_min_q;
      REG_OUT_MAX:    prdata = out_max_q;
      REG_START_ERR:  prdata = start_err_q;
      REG_START_MEAS: prdata = start_meas_q;
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_LOAD;
          op_d    = OP_P;
        end
      end
      ST_LOAD:  state_d = ST_MUL;
      ST_MUL: begin
        if (mul_done) begin
          if (op_q == OP_B) begin
            state_d = ST_DLOAD;
          end else begin
            state_d = ST_LOAD;
            op_d    = op_e'(op_q + 3'd1);
          end
        end
      end
      ST_DLOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_fire) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = state_q != ST_IDLE;
    mul_start  = state_q == ST_LOAD;
    div_start  = state_q == ST_DLOAD;
    fin_fire   = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    err_c = sat66(66'(setpoint_q) - 66'(sample_i));
    dm_c  = sat66(66'(sample_i) - 66'(prev_meas_q));
    e2    = sat66(66'(err_q) + 66'(prev_err_q));
  end

  always_comb begin
    mul_a = gain_p_q;
    mul_b = MB_W'(err_q);
    case (op_q)
      OP_P: begin
        mul_a = gain_p_q;
        mul_b = MB_W'(err_q);
      end
      OP_KI: begin
        mul_a = gain_i_q;
        mul_b = $signed({{(MB_W-DT_W){1'b0}}, dt_q});
      end
      OP_INC: begin
        mul_a = kidt_q;
        mul_b = MB_W'(e2);
      end
      OP_A: begin
        mul_a = gain_d_q;
        mul_b = MB_W'(dm_q);
      end
      OP_B: begin
        mul_a = deriv_q;
        mul_b = MB_W'(TWO_TAU) - $signed({{(MB_W-DT_W){1'b0}}, dt_q});
      end
      default: begin
        mul_a = gain_p_q;
        mul_b = MB_W'(err_q);
      end
    endcase
  end

  pidc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  always_comb begin
    prod_w = mul_prod[65:0];
    case (op_q)
      OP_INC:  rounded = (prod_w + RND_F1) >>> (FRAC_BITS + 1);
      OP_A:    rounded = (prod_w + RND_FM) >>> (FRAC_BITS - 1);
      default: rounded = (prod_w + RND_F) >>> FRAC_BITS;
    endcase
    rnd_sat = sat66(rounded);
  end

  always_comb begin
    num_w   = 33'(a_q) + 33'(b_q);
    num_s   = sat66(66'(num_w));
    num_mag = num_s[31] ? (32'd0 - num_s) : num_s;
    div_num = (NW'(num_mag) << FRAC_BITS) + NW'(den_q >> 1);
  end

  pidc_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    integ_sum = 34'(integ_q) + 34'(inc_q);
    integ_s   = sat66(66'(integ_sum));
    hi_w      = 34'(out_max_q) - 34'(prop_q);
    lo_w      = 34'(out_min_q) - 34'(prop_q);
    hi_i      = (out_max_q > prop_q) ? sat66(66'(hi_w)) : '0;
    lo_i      = (out_min_q < prop_q) ? sat66(66'(lo_w)) : '0;
    if (integ_s > hi_i) begin
      integ_c = hi_i;
    end else if (integ_s < lo_i) begin
      integ_c = lo_i;
    end else begin
      integ_c = integ_s;
    end
    if (neg_q) begin
      deriv_c = sat66($signed({{(66-NW){1'b0}}, div_quo}));
    end else begin
      deriv_c = sat66(-$signed({{(66-NW){1'b0}}, div_quo}));
    end
    drive_w = 34'(prop_q) + 34'(integ_c) + 34'(deriv_c);
    drive_s = sat66(66'(drive_w));
    if (drive_s > out_max_q) begin
      drive_c = out_max_q;
    end else if (drive_s < out_min_q) begin
      drive_c = out_min_q;
    end else begin
      drive_c = drive_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= OP_P;
      out_valid_q  <= 1'b0;
      gain_p_q     <= '0;
      gain_i_q     <= '0;
      gain_d_q     <= '0;
      setpoint_q   <= '0;
      out_min_q    <= 32'sh80000000;
      out_max_q    <= 32'sh7fffffff;
      start_err_q  <= '0;
      start_meas_q <= '0;
      prev_err_q   <= '0;
      prev_meas_q  <= '0;
      integ_q      <= '0;
      deriv_q      <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      if (fin_fire) begin
        out_valid_q <= 1'b1;
        prev_err_q  <= err_q;
        prev_meas_q <= sample_q;
        integ_q     <= integ_c;
        deriv_q     <= deriv_c;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        case (paddr[4:2])
          REG_GAIN_P:   gain_p_q   <= pwdata;
          REG_GAIN_I:   gain_i_q   <= pwdata;
          REG_GAIN_D:   gain_d_q   <= pwdata;
          REG_SETPOINT: setpoint_q <= pwdata;
          REG_OUT_MIN:  out_min_q  <= pwdata;
          REG_OUT_MAX:  out_max_q  <= pwdata;
          REG_START_ERR: begin
            start_err_q <= pwdata;
            prev_err_q  <= pwdata;
          end
          REG_START_MEAS: begin
            start_meas_q <= pwdata;
            prev_meas_q  <= pwdata;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= sample_i;
      dt_q     <= step_time_i;
      den_q    <= DW'(TWO_TAU) + DW'(step_time_i);
      err_q    <= err_c;
      dm_q     <= dm_c;
    end
    if (state_q == ST_MUL && mul_done) begin
      case (op_q)
        OP_P:    prop_q <= rnd_sat;
        OP_KI:   kidt_q <= rnd_sat;
        OP_INC:  inc_q  <= rnd_sat;
        OP_A:    a_q    <= rnd_sat;
        OP_B:    b_q    <= rnd_sat;
        default: prop_q <= rnd_sat;
      endcase
    end
    if (div_start) begin
      neg_q <= num_s[31];
    end
    if (fin_fire) begin
      drive_q <= drive_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

endmodule
